// ----- rtl/i2cmbe_pkg.sv -----
package i2cmbe_pkg;

    // Command codes carried on the slave-side tuser
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Configuration register indexes
    localparam int          CFG_IDX_W          = 1;
    localparam logic [0:0]  CFG_HALF_BIT_TICKS = 1'd0;
    localparam logic [0:0]  CFG_ACK_TIMEOUT    = 1'd1;

    // Configuration reset values
    localparam logic [7:0]  HALF_BIT_RESET     = 8'd4;
    localparam logic [7:0]  ACK_TIMEOUT_RESET  = 8'd250;

    // Default depth of the queue between front and back
    localparam int          QUEUE_DEPTH_DEF    = 4;

    // Packed widths of the stream payloads
    localparam int          IN_DATA_W          = 16;
    localparam int          IN_USER_W          = 3;
    localparam int          OUT_DATA_W         = 16;

    // One classified tick as it travels through the queue
    typedef struct packed {
        logic       start;
        logic       stop;
        logic       write;
        logic       read;
        logic [7:0] wr_data;
        logic       send_nack;
        logic       sda_in;
    } item_t;

    // Live configuration seen by the back end
    typedef struct packed {
        logic [7:0] half_bit_ticks;
        logic [7:0] ack_timeout;
    } cfg_t;

endpackage

// ----- rtl/i2cmbe_front.sv -----
module i2cmbe_front
(
    input  logic [i2cmbe_pkg::IN_USER_W-1:0] cmd,
    input  logic [i2cmbe_pkg::IN_DATA_W-1:0] data,
    output i2cmbe_pkg::item_t                item
);

    // Classify the command; unknown codes become a plain tick
    always_comb
    begin
        item           = '0;
        item.wr_data   = data[7:0];
        item.send_nack = data[8];
        item.sda_in    = data[9];
        unique case (cmd)
            i2cmbe_pkg::CMD_START: item.start = 1'b1;
            i2cmbe_pkg::CMD_STOP:  item.stop  = 1'b1;
            i2cmbe_pkg::CMD_WRITE: item.write = 1'b1;
            i2cmbe_pkg::CMD_READ:  item.read  = 1'b1;
            default:               ;
        endcase
    end

endmodule

// ----- rtl/i2cmbe_queue.sv -----
module i2cmbe_queue
#(
    parameter int DEPTH = i2cmbe_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  i2cmbe_pkg::item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output i2cmbe_pkg::item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    i2cmbe_pkg::item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = mem[rd_ptr_reg];

    // Advance pointers with wrap and track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/i2cmbe_back.sv -----
module i2cmbe_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  i2cmbe_pkg::cfg_t                  cfg,
    input  logic                              item_valid,
    input  i2cmbe_pkg::item_t                 item,
    output logic                              item_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2cmbe_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_START_A = 4'd1;
    localparam logic [3:0] PH_START_B = 4'd2;
    localparam logic [3:0] PH_STOP_A  = 4'd3;
    localparam logic [3:0] PH_STOP_B  = 4'd4;
    localparam logic [3:0] PH_WR_LOW  = 4'd5;
    localparam logic [3:0] PH_WR_HIGH = 4'd6;
    localparam logic [3:0] PH_WA_LOW  = 4'd7;
    localparam logic [3:0] PH_WA_HIGH = 4'd8;
    localparam logic [3:0] PH_RD_LOW  = 4'd9;
    localparam logic [3:0] PH_RD_HIGH = 4'd10;
    localparam logic [3:0] PH_RA_LOW  = 4'd11;
    localparam logic [3:0] PH_RA_HIGH = 4'd12;

    logic [3:0] phase_reg,   phase_next;
    logic [3:0] bit_idx_reg, bit_idx_next;
    logic [7:0] shift_reg,   shift_next;
    logic [7:0] tick_reg,    tick_next;
    logic [7:0] ackw_reg,    ackw_next;
    logic       scl_reg,     scl_next;
    logic       sda_reg,     sda_next;
    logic       nack_reg,    nack_next;
    logic [7:0] rd_byte_reg, rd_byte_next;
    logic       rd_nack_reg, rd_nack_next;

    logic                              out_valid_reg;
    logic [i2cmbe_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic       done;
    logic [7:0] hb;
    logic [7:0] tick_inc;
    logic [3:0] bit_idx_inc;

    // Take the next tick whenever the output slot is free or draining
    assign item_pop = item_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Bus sequencer: one tick per popped item
    always_comb
    begin
        phase_next   = phase_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        tick_next    = tick_reg;
        ackw_next    = ackw_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        nack_next    = nack_reg;
        rd_byte_next = rd_byte_reg;
        rd_nack_next = rd_nack_reg;
        done         = 1'b0;
        hb           = (cfg.half_bit_ticks == '0) ? 8'd1 : cfg.half_bit_ticks;
        tick_inc     = tick_reg + 8'd1;
        bit_idx_inc  = bit_idx_reg + 4'd1;

        if (phase_reg == PH_IDLE)
        begin
            // Launch a command
            if (item.start)
            begin
                phase_next = PH_START_A;
                scl_next   = 1'b1;
                sda_next   = 1'b1;
                tick_next  = '0;
            end
            else if (item.stop)
            begin
                phase_next = PH_STOP_A;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                tick_next  = '0;
            end
            else if (item.write)
            begin
                shift_next   = item.wr_data;
                bit_idx_next = '0;
                nack_next    = 1'b0;
                phase_next   = PH_WR_LOW;
                scl_next     = 1'b0;
                sda_next     = item.wr_data[7];
                tick_next    = '0;
            end
            else if (item.read)
            begin
                shift_next   = '0;
                bit_idx_next = '0;
                rd_nack_next = item.send_nack;
                phase_next   = PH_RD_LOW;
                scl_next     = 1'b0;
                sda_next     = 1'b1;
                tick_next    = '0;
            end
        end
        else if (phase_reg == PH_WA_HIGH)
        begin
            // Wait for the slave to pull SDA low, or time out into a stop
            if (!item.sda_in)
            begin
                nack_next  = 1'b0;
                scl_next   = 1'b0;
                phase_next = PH_IDLE;
                done       = 1'b1;
            end
            else if (ackw_reg >= cfg.ack_timeout)
            begin
                nack_next  = 1'b1;
                phase_next = PH_STOP_A;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                tick_next  = '0;
            end
            else
            begin
                ackw_next = ackw_reg + 8'd1;
            end
        end
        else
        begin
            // Timed segments: advance when the half bit expires
            tick_next = tick_inc;
            if (tick_inc >= hb)
            begin
                tick_next = '0;
                unique case (phase_reg)
                    PH_START_A:
                    begin
                        phase_next = PH_START_B;
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                    end
                    PH_START_B:
                    begin
                        tick_next  = tick_inc;
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_STOP_A:
                    begin
                        phase_next = PH_STOP_B;
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                    end
                    PH_STOP_B:
                    begin
                        tick_next  = tick_inc;
                        sda_next   = 1'b1;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_WR_LOW:
                    begin
                        phase_next = PH_WR_HIGH;
                        scl_next   = 1'b1;
                    end
                    PH_WR_HIGH:
                    begin
                        shift_next   = {shift_reg[6:0], 1'b0};
                        bit_idx_next = bit_idx_inc;
                        scl_next     = 1'b0;
                        if (bit_idx_inc < 4'd8)
                        begin
                            phase_next = PH_WR_LOW;
                            sda_next   = shift_reg[6];
                        end
                        else
                        begin
                            phase_next = PH_WA_LOW;
                            sda_next   = 1'b1;
                        end
                    end
                    PH_WA_LOW:
                    begin
                        ackw_next  = '0;
                        phase_next = PH_WA_HIGH;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                    end
                    PH_RD_LOW:
                    begin
                        phase_next = PH_RD_HIGH;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                    end
                    PH_RD_HIGH:
                    begin
                        shift_next   = {shift_reg[6:0], item.sda_in};
                        bit_idx_next = bit_idx_inc;
                        scl_next     = 1'b0;
                        if (bit_idx_inc < 4'd8)
                        begin
                            phase_next = PH_RD_LOW;
                            sda_next   = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RA_LOW;
                            sda_next   = rd_nack_reg;
                        end
                    end
                    PH_RA_LOW:
                    begin
                        phase_next = PH_RA_HIGH;
                        scl_next   = 1'b1;
                        sda_next   = rd_nack_reg;
                    end
                    PH_RA_HIGH:
                    begin
                        tick_next    = tick_inc;
                        rd_byte_next = shift_reg;
                        scl_next     = 1'b0;
                        phase_next   = PH_IDLE;
                        done         = 1'b1;
                    end
                    default:
                    begin
                        tick_next  = tick_inc;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Update engine state and load the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            tick_reg      <= '0;
            ackw_reg      <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            nack_reg      <= 1'b0;
            rd_byte_reg   <= '0;
            rd_nack_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_pop)
            begin
                phase_reg     <= phase_next;
                bit_idx_reg   <= bit_idx_next;
                shift_reg     <= shift_next;
                tick_reg      <= tick_next;
                ackw_reg      <= ackw_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                nack_reg      <= nack_next;
                rd_byte_reg   <= rd_byte_next;
                rd_nack_reg   <= rd_nack_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            out_data_reg <= {3'b000, nack_next, rd_byte_next, done,
                             (phase_next != PH_IDLE), sda_next, scl_next};
        end
    end

endmodule

// ----- rtl/i2c_master_byte_engine.sv -----
// Channel  | Dir | Signals                        | Contents
// slave    | in  | s_tvalid s_tready s_tdata s_tuser | one bus tick, optional command
// master   | out | m_tvalid m_tready m_tdata      | line levels and status after the tick
// config   | in  | cfg_we cfg_addr cfg_wdata      | 0 half_bit_ticks, 1 ack_timeout
//
// One tick per clock cycle sustained while m_tready is high; a tick's result is presented
// through the queue entry written at acceptance, then the sequencer result register.
// The sequencer updates bus state once per tick; that step sets the rate.
// Reset is asynchronous, active low; SCL and SDA come up released.
// A stalled master side fills the queue, then drops s_tready.
module i2c_master_byte_engine
#(
    parameter int QUEUE_DEPTH = i2cmbe_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [7:0] wr_data, [8] send_nack, [9] sda_in, [15:10] zero
    input  logic [i2cmbe_pkg::IN_DATA_W-1:0]   s_tdata,
    // [2:0] cmd
    input  logic [i2cmbe_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] scl, [1] sda_release, [2] busy_res, [3] done_res,
    // [11:4] read_data, [12] ack_failed, [15:13] zero
    output logic [i2cmbe_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                               cfg_we,
    input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [7:0]                         cfg_wdata
);

    i2cmbe_pkg::item_t front_item;
    i2cmbe_pkg::item_t queue_item;
    i2cmbe_pkg::cfg_t  cfg;
    logic              queue_full;
    logic              queue_not_empty;
    logic              queue_pop;
    logic [7:0]        half_bit_reg;
    logic [7:0]        ack_timeout_reg;

    assign s_tready           = !queue_full;
    assign cfg.half_bit_ticks = half_bit_reg;
    assign cfg.ack_timeout    = ack_timeout_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_reg    <= i2cmbe_pkg::HALF_BIT_RESET;
            ack_timeout_reg <= i2cmbe_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                i2cmbe_pkg::CFG_HALF_BIT_TICKS: half_bit_reg    <= cfg_wdata;
                i2cmbe_pkg::CFG_ACK_TIMEOUT:    ack_timeout_reg <= cfg_wdata;
                default:                        ;
            endcase
        end
    end

    i2cmbe_front u_front
    (
        .cmd  (s_tuser),
        .data (s_tdata),
        .item (front_item)
    );

    i2cmbe_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_item  (queue_item)
    );

    i2cmbe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (queue_not_empty),
        .item       (queue_item),
        .item_pop   (queue_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
